// File: hdl/cw_break_in_sequencer_top_assert.svh
// ----------------------------------------------------------------------------
// CW break-in sequencer assertion macros
// Concurrent assertion wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef CW_BREAK_IN_SEQUENCER_TOP_ASSERT_SVH
`define CW_BREAK_IN_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CWBI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CWBI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CWBI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define CWBI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/cwbi_pkg.sv
// ----------------------------------------------------------------------------
// CW break-in sequencer package
// Shared types, register indexes and constants of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwbi_pkg;

  localparam int FREQ_BITS_DEF       = 28;
  localparam int HANG_COUNT_BITS_DEF = 12;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam int HANG_MS_BITS = 12;
  localparam logic [HANG_MS_BITS-1:0] HANG_MIN_MS  = 12'd50;
  localparam logic [HANG_MS_BITS-1:0] HANG_UNIT_MS = 12'd10;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CW_SELECTED   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_BREAK_IN = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PITCH_OFFSET  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HANG_TIME     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIN_KEYING    = 3'd4;

  localparam logic [15:0] PITCH_OFFSET_RST = 16'd600;
  localparam logic [7:0]  HANG_TIME_RST    = 8'd5;

  typedef struct packed {
    logic        cw_selected;
    logic        full_break_in;
    logic [15:0] pitch_offset;
    logic [7:0]  hang_time;
    logic        din_keying;
  } cfg_t;

  typedef struct packed {
    logic paddle_a_level;
    logic paddle_b_level;
    logic synth_ok;
    logic tx_lockout;
    logic ms_tick;
  } item_t;

  typedef struct packed {
    logic amp_line;
    logic rx_line;
    logic dout_line;
    logic din_line;
    logic key_active;
    logic synth_write;
    logic hang_active;
  } result_t;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_WAIT_KEY  = 9'b000000010,
    ST_START     = 9'b000000100,
    ST_MARK      = 9'b000001000,
    ST_DROP_RX   = 9'b000010000,
    ST_MARK_HOLD = 9'b000100000,
    ST_SPACE     = 9'b001000000,
    ST_HANG      = 9'b010000000,
    ST_HANG_POLL = 9'b100000000
  } seq_state_e;

endpackage

// File: hdl/cw_break_in_sequencer_top.sv
// ----------------------------------------------------------------------------
// CW break-in sequencer top level
// Input register, sequencer core, result register and configuration port.
// ----------------------------------------------------------------------------
// Usage: each input request is one poll tick of the keying loop, carrying the
// paddle levels, LO frequency, synthesizer write outcome, TX lockout and a
// millisecond tick. Each accepted request yields exactly one result request
// with the line levels, session and hold flags and the synthesizer write.
// Configuration writes use their own channel and are always ready. The user must
// make them only while no request is in flight; the block does not enforce this.
// The result is registered: a request passes the input register, the
// next-state logic and the result register. Throughput is one request per
// cycle while the receiver takes results, set by the single pass through the
// next-state logic between the input register and the result register.
// Reset puts the sequence in idle with AMP, RX and DOUT high, DIN low, and
// the registers at their defaults. When the receiver stalls, the result
// register holds and the input register still takes one more request; after
// that input ready drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cw_break_in_sequencer_top_assert.svh"

module cw_break_in_sequencer_top #(
  parameter int FREQ_BITS       = cwbi_pkg::FREQ_BITS_DEF,
  parameter int HANG_COUNT_BITS = cwbi_pkg::HANG_COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cwbi_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [cwbi_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                paddle_a_level_i,
  input  logic                                paddle_b_level_i,
  input  logic [FREQ_BITS-1:0]                lo_freq_i,
  input  logic                                synth_ok_i,
  input  logic                                tx_lockout_i,
  input  logic                                ms_tick_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                amp_line_o,
  output logic                                rx_line_o,
  output logic                                dout_line_o,
  output logic                                din_line_o,
  output logic                                key_active_o,
  output logic                                synth_write_o,
  output logic [FREQ_BITS-1:0]                synth_freq_o,
  output logic                                hang_active_o
);

  cwbi_pkg::cfg_t     cfg;
  cwbi_pkg::item_t    item_q;
  cwbi_pkg::result_t  res, res_q;
  logic               in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic [FREQ_BITS-1:0] lo_q, freq, freq_q;
  logic               advance, step, in_take;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_take ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = step ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  cwbi_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cwbi_seq_core #(
    .FREQ_BITS       (FREQ_BITS),
    .HANG_COUNT_BITS (HANG_COUNT_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .cfg_i        (cfg),
    .item_i       (item_q),
    .lo_freq_i    (lo_q),
    .res_o        (res),
    .synth_freq_o (freq)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.paddle_a_level <= paddle_a_level_i;
      item_q.paddle_b_level <= paddle_b_level_i;
      item_q.synth_ok       <= synth_ok_i;
      item_q.tx_lockout     <= tx_lockout_i;
      item_q.ms_tick        <= ms_tick_i;
      lo_q                  <= lo_freq_i;
    end
    if (step) begin
      res_q  <= res;
      freq_q <= freq;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign amp_line_o    = res_q.amp_line;
  assign rx_line_o     = res_q.rx_line;
  assign dout_line_o   = res_q.dout_line;
  assign din_line_o    = res_q.din_line;
  assign key_active_o  = res_q.key_active;
  assign synth_write_o = res_q.synth_write;
  assign synth_freq_o  = freq_q;
  assign hang_active_o = res_q.hang_active;

  `CWBI_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !advance,
                    in_valid_q && $stable(lo_q) && $stable(item_q),
                    "Pending input request lost or changed during a stall.")
  `CWBI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i,
                    out_valid_q && $stable(res_q) && $stable(freq_q),
                    "Pending result request lost or changed during a stall.")
  `CWBI_ASSERT_IMPL(a_in_block, clk_i, rst_ni, in_valid_q && !advance, !in_ready_o,
                    "Input ready raised while both registers are full.")

endmodule

// File: hdl/cwbi_cfg_regs.sv
// ----------------------------------------------------------------------------
// CW break-in sequencer configuration registers
// Register file written through the configuration request channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwbi_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cwbi_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [cwbi_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output cwbi_pkg::cfg_t                       cfg_o
);

  cwbi_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        cwbi_pkg::CFG_CW_SELECTED:   cfg_d.cw_selected   = cfg_data_i[0];
        cwbi_pkg::CFG_FULL_BREAK_IN: cfg_d.full_break_in = cfg_data_i[0];
        cwbi_pkg::CFG_PITCH_OFFSET:  cfg_d.pitch_offset  = cfg_data_i[15:0];
        cwbi_pkg::CFG_HANG_TIME:     cfg_d.hang_time     = cfg_data_i[7:0];
        cwbi_pkg::CFG_DIN_KEYING:    cfg_d.din_keying    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cw_selected   <= 1'b0;
      cfg_q.full_break_in <= 1'b0;
      cfg_q.pitch_offset  <= cwbi_pkg::PITCH_OFFSET_RST;
      cfg_q.hang_time     <= cwbi_pkg::HANG_TIME_RST;
      cfg_q.din_keying    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hdl/cwbi_seq_core.sv
// ----------------------------------------------------------------------------
// CW break-in sequencer core
// Sequence state, hang countdown and line levels, advanced one poll per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cw_break_in_sequencer_top_assert.svh"

module cwbi_seq_core #(
  parameter int FREQ_BITS       = cwbi_pkg::FREQ_BITS_DEF,
  parameter int HANG_COUNT_BITS = cwbi_pkg::HANG_COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  cwbi_pkg::cfg_t        cfg_i,
  input  cwbi_pkg::item_t       item_i,
  input  logic [FREQ_BITS-1:0]  lo_freq_i,
  output cwbi_pkg::result_t     res_o,
  output logic [FREQ_BITS-1:0]  synth_freq_o
);

  cwbi_pkg::seq_state_e         state_q, state_d;
  logic [FREQ_BITS-1:0]         last_lo_q, last_lo_d;
  logic                         hold_q, hold_d;
  logic [HANG_COUNT_BITS-1:0]   cnt_q, cnt_d;
  logic                         run_q, run_d;
  logic                         amp_q, amp_d, rx_q, rx_d, dout_q, dout_d, din_q, din_d;
  logic                         sess_q, sess_d;

  logic                               key_down, legacy, may_start, wr;
  logic [FREQ_BITS-1:0]               wf, tx_freq;
  logic [FREQ_BITS:0]                 freq_sum;
  logic [cwbi_pkg::HANG_MS_BITS-1:0]  hang_ms, hang_ms_min;
  logic [HANG_COUNT_BITS-1:0]         hang_load;

  assign key_down  = !item_i.paddle_a_level || !item_i.paddle_b_level;
  assign legacy    = cfg_i.din_keying;
  assign may_start = !item_i.tx_lockout && cfg_i.cw_selected;

  assign freq_sum = {1'b0, lo_freq_i} + (FREQ_BITS + 1)'(cfg_i.pitch_offset);
  assign tx_freq  = freq_sum[FREQ_BITS] ? {FREQ_BITS{1'b1}} : freq_sum[FREQ_BITS-1:0];

  // Longest hang (2550 ms) fits the default 12-bit count; narrower ones truncate.
  assign hang_ms     = cwbi_pkg::HANG_MS_BITS'(cfg_i.hang_time) * cwbi_pkg::HANG_UNIT_MS;
  assign hang_ms_min = (hang_ms < cwbi_pkg::HANG_MIN_MS) ? cwbi_pkg::HANG_MIN_MS : hang_ms;
  assign hang_load   = HANG_COUNT_BITS'(hang_ms_min);

  always_comb begin
    state_d   = state_q;
    last_lo_d = last_lo_q;
    hold_d    = hold_q;
    cnt_d     = cnt_q;
    run_d     = run_q;
    amp_d     = amp_q;
    rx_d      = rx_q;
    dout_d    = dout_q;
    din_d     = din_q;
    sess_d    = sess_q;
    wr        = 1'b0;
    wf        = '0;
    if (step_i) begin
      if (item_i.ms_tick && run_q) begin
        if (cnt_q <= HANG_COUNT_BITS'(1)) begin
          cnt_d  = '0;
          run_d  = 1'b0;
          hold_d = 1'b0;
        end else begin
          cnt_d = cnt_q - HANG_COUNT_BITS'(1);
        end
      end
      case (state_q)
        cwbi_pkg::ST_IDLE: begin
          if (last_lo_q != lo_freq_i) begin
            wr = 1'b1;
            wf = lo_freq_i;
            if (item_i.synth_ok) begin
              last_lo_d = lo_freq_i;
              if (may_start) state_d = cwbi_pkg::ST_WAIT_KEY;
            end
          end else if (may_start) begin
            state_d = cwbi_pkg::ST_WAIT_KEY;
          end
        end
        cwbi_pkg::ST_WAIT_KEY: begin
          if (key_down) begin
            sess_d  = 1'b1;
            state_d = cwbi_pkg::ST_START;
          end else begin
            state_d = cwbi_pkg::ST_IDLE;
          end
        end
        cwbi_pkg::ST_START: begin
          dout_d = 1'b0;
          if (legacy) din_d = 1'b0;
          wr = 1'b1;
          wf = tx_freq;
          if (item_i.synth_ok) state_d = cwbi_pkg::ST_MARK;
        end
        cwbi_pkg::ST_MARK: begin
          amp_d = 1'b0;
          if (legacy) begin
            rx_d    = 1'b0;
            din_d   = 1'b1;
            hold_d  = 1'b1;
            state_d = cwbi_pkg::ST_MARK_HOLD;
          end else if (cfg_i.full_break_in) begin
            rx_d    = 1'b0;
            hold_d  = 1'b1;
            state_d = cwbi_pkg::ST_MARK_HOLD;
          end else begin
            state_d = cwbi_pkg::ST_DROP_RX;
          end
        end
        cwbi_pkg::ST_DROP_RX: begin
          if (legacy) begin
            state_d = cwbi_pkg::ST_IDLE;
          end else begin
            rx_d    = 1'b0;
            hold_d  = 1'b1;
            state_d = cwbi_pkg::ST_MARK_HOLD;
          end
        end
        cwbi_pkg::ST_MARK_HOLD: begin
          if (!key_down) state_d = cwbi_pkg::ST_SPACE;
        end
        cwbi_pkg::ST_SPACE: begin
          if (legacy) din_d = 1'b0;
          else rx_d = 1'b1;
          cnt_d   = hang_load;
          run_d   = 1'b1;
          state_d = cwbi_pkg::ST_HANG;
        end
        cwbi_pkg::ST_HANG: begin
          if (!hold_d) begin
            wr = 1'b1;
            wf = lo_freq_i;
            if (item_i.synth_ok) begin
              amp_d  = 1'b1;
              dout_d = 1'b1;
              if (legacy) rx_d = 1'b1;
              sess_d  = 1'b0;
              state_d = cwbi_pkg::ST_IDLE;
            end
          end else begin
            state_d = cwbi_pkg::ST_HANG_POLL;
          end
        end
        cwbi_pkg::ST_HANG_POLL: begin
          if (key_down) state_d = legacy ? cwbi_pkg::ST_MARK : cwbi_pkg::ST_DROP_RX;
          else state_d = cwbi_pkg::ST_HANG;
        end
        default: state_d = cwbi_pkg::ST_IDLE;
      endcase
    end
  end

  assign res_o.amp_line    = amp_d;
  assign res_o.rx_line     = rx_d;
  assign res_o.dout_line   = dout_d;
  assign res_o.din_line    = din_d;
  assign res_o.key_active  = sess_d;
  assign res_o.synth_write = wr;
  assign res_o.hang_active = hold_d;
  assign synth_freq_o      = wf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cwbi_pkg::ST_IDLE;
      last_lo_q <= '0;
      hold_q    <= 1'b0;
      cnt_q     <= '0;
      run_q     <= 1'b0;
      amp_q     <= 1'b1;
      rx_q      <= 1'b1;
      dout_q    <= 1'b1;
      din_q     <= 1'b0;
      sess_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_lo_q <= last_lo_d;
      hold_q    <= hold_d;
      cnt_q     <= cnt_d;
      run_q     <= run_d;
      amp_q     <= amp_d;
      rx_q      <= rx_d;
      dout_q    <= dout_d;
      din_q     <= din_d;
      sess_q    <= sess_d;
    end
  end

  `CWBI_ASSERT_IMPL(a_run_count, clk_i, rst_ni, run_q, cnt_q != '0,
                    "Hang countdown runs with a zero count.")
  `CWBI_ASSERT_IMPL(a_hold_lines, clk_i, rst_ni, state_q == cwbi_pkg::ST_MARK_HOLD,
                    !amp_q && !rx_q && !dout_q, "Mark hold with a line still raised.")
  `CWBI_ASSERT_IMPL(a_poll_hold, clk_i, rst_ni, state_q == cwbi_pkg::ST_HANG_POLL,
                    hold_q, "Hang poll entered without the hold flag.")

endmodule
